// File: sv/arq_pkg.sv
// Shared constants, codes and control types of the acked report queue.
package arq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int KEYBOARD_BYTES = 8;
  localparam int CONSUMER_BYTES = 2;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int KB_W   = KEYBOARD_BYTES * 8;
  localparam int CB_W   = CONSUMER_BYTES * 8;
  localparam int SEQ_W  = 32;
  localparam int KIND_W = 8;
  localparam int LEN_W  = 8;
  localparam int DATA_W = 64;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KBD_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CON_CODE = 1'd1;

  localparam logic [KIND_W-1:0] KBD_CODE_RST = 8'd1;
  localparam logic [KIND_W-1:0] CON_CODE_RST = 8'd2;

  typedef enum logic [1:0] {
    CMD_PUSH       = 2'd0,
    CMD_ACK        = 2'd1,
    CMD_SESSION    = 2'd2,
    CMD_DISCONNECT = 2'd3
  } arq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISMATCH = 2'd3
  } arq_status_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic sess2;
    logic load_out;
  } arq_ctl_t;

  typedef struct packed {
    logic is_session;
    logic out_free;
  } arq_stat_t;

endpackage

// File: sv/arq_ctrl.sv
// Sequencing state machine of the acked report queue.
module arq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  arq_pkg::arq_stat_t stat_i,
  output arq_pkg::arq_ctl_t  ctl_o
);
  import arq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SESS2,
    S_READ,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_comb begin
    ctl_o.latch    = ready_q && in_valid_i;
    ctl_o.exec     = (state_q == S_EXEC);
    ctl_o.sess2    = (state_q == S_SESS2);
    ctl_o.load_out = (state_q == S_RESULT) && stat_i.out_free;
  end

  assign in_ready_o = ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= stat_i.is_session ? S_SESS2 : S_READ;
        end
        S_SESS2: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |=> (state_q == S_EXEC))
    else $error("accepted word did not start execution");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == S_IDLE))
    else $error("ready outside idle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |=> !ready_q || (state_q == S_IDLE))
    else $error("result load did not return to idle");

endmodule

// File: sv/arq_datapath.sv
// Ring, latest reports, sequence counter and result register of the queue.
module arq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [arq_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [1:0]                          in_cmd_i,
  input  logic [arq_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [arq_pkg::OUT_TDATA_W-1:0]     out_data_o,
  input  arq_pkg::arq_ctl_t                   ctl_i,
  output arq_pkg::arq_stat_t                  stat_o
);
  import arq_pkg::*;

  // configuration
  logic [KIND_W-1:0] kbd_code_q, con_code_q;

  // latched word
  arq_cmd_e          cmd_q;
  logic [KIND_W-1:0] kind_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] data_q;
  logic [SEQ_W-1:0]  ack_q;

  // queue state
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SEQ_W-1:0] next_seq_q, next_seq_d;
  logic             online_q, online_d;
  logic [KB_W-1:0]  latest_kbd_q, latest_kbd_d;
  logic [CB_W-1:0]  latest_con_q, latest_con_d;
  arq_status_e      status_q, status_d;
  logic             queued_q, queued_d;

  // ring
  logic [SEQ_W-1:0]  seq_mem  [QUEUE_DEPTH];
  logic [KIND_W-1:0] kind_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];
  logic [SEQ_W-1:0]  rd_seq_q;
  logic [KIND_W-1:0] rd_kind_q;
  logic [DATA_W-1:0] rd_data_q;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [SEQ_W-1:0]  wr_seq;
  logic [KIND_W-1:0] wr_kind;
  logic [DATA_W-1:0] wr_data;

  // result
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [IDX_W:0]    slot_sum;
  logic [IDX_W-1:0]  tail_slot;
  logic [IDX_W-1:0]  head_next;
  logic              can_enq;
  logic              is_kbd, is_con, len_ok;
  logic [KB_W-1:0]   v_kbd;
  logic [CB_W-1:0]   v_con;
  logic              differs;
  logic              head_valid;
  logic [SEQ_W-1:0]  show_seq;
  logic [KIND_W-1:0] show_kind;
  logic [DATA_W-1:0] show_data;

  always_comb begin
    slot_sum  = (IDX_W+1)'(head_q) + (IDX_W+1)'(cnt_q);
    tail_slot = (slot_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                ? IDX_W'(slot_sum - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
    head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
    can_enq   = (cnt_q != CNT_W'(QUEUE_DEPTH)) && (next_seq_q != '1);
    is_kbd    = (kind_q == kbd_code_q);
    is_con    = !is_kbd && (kind_q == con_code_q);
    len_ok    = (is_kbd && (len_q == LEN_W'(KEYBOARD_BYTES)))
             || (is_con && (len_q == LEN_W'(CONSUMER_BYTES)));
    v_kbd     = data_q[KB_W-1:0];
    v_con     = data_q[CB_W-1:0];
    differs   = is_kbd ? (latest_kbd_q != v_kbd) : (latest_con_q != v_con);
  end

  always_comb begin
    head_d       = head_q;
    cnt_d        = cnt_q;
    next_seq_d   = next_seq_q;
    online_d     = online_q;
    latest_kbd_d = latest_kbd_q;
    latest_con_d = latest_con_q;
    status_d     = status_q;
    queued_d     = queued_q;
    wr_en        = 1'b0;
    wr_addr      = tail_slot;
    wr_seq       = next_seq_q;
    wr_kind      = kind_q;
    wr_data      = is_kbd ? DATA_W'(v_kbd) : DATA_W'(v_con);
    if (ctl_i.exec) begin
      status_d = ST_OK;
      queued_d = 1'b0;
      case (cmd_q)
        CMD_PUSH: begin
          if (!len_ok) begin
            status_d = ST_INVALID;
          end else if (differs) begin
            if (is_kbd) begin
              latest_kbd_d = v_kbd;
            end else begin
              latest_con_d = v_con;
            end
            if (online_q) begin
              if (can_enq) begin
                wr_en      = 1'b1;
                next_seq_d = next_seq_q + SEQ_W'(1);
                cnt_d      = cnt_q + CNT_W'(1);
                queued_d   = 1'b1;
              end else begin
                status_d = ST_FULL;
              end
            end
          end
        end
        CMD_ACK: begin
          if ((cnt_q == '0) || (rd_seq_q != ack_q)) begin
            status_d = ST_MISMATCH;
          end else begin
            head_d = head_next;
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
        CMD_SESSION: begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_seq     = SEQ_W'(1);
          wr_kind    = kbd_code_q;
          wr_data    = DATA_W'(latest_kbd_q);
          head_d     = '0;
          cnt_d      = CNT_W'(1);
          next_seq_d = SEQ_W'(2);
          online_d   = 1'b1;
        end
        CMD_DISCONNECT: begin
          head_d   = '0;
          cnt_d    = '0;
          online_d = 1'b0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end else if (ctl_i.sess2) begin
      wr_en      = 1'b1;
      wr_kind    = con_code_q;
      wr_data    = DATA_W'(latest_con_q);
      next_seq_d = next_seq_q + SEQ_W'(1);
      cnt_d      = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_code_q   <= KBD_CODE_RST;
      con_code_q   <= CON_CODE_RST;
      head_q       <= '0;
      cnt_q        <= '0;
      next_seq_q   <= '0;
      online_q     <= 1'b0;
      latest_kbd_q <= '0;
      latest_con_q <= '0;
      status_q     <= ST_OK;
      queued_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KBD_CODE: kbd_code_q <= cfg_wdata_i;
          REG_CON_CODE: con_code_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      next_seq_q   <= next_seq_d;
      online_q     <= online_d;
      latest_kbd_q <= latest_kbd_d;
      latest_con_q <= latest_con_d;
      status_q     <= status_d;
      queued_q     <= queued_d;
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= arq_cmd_e'(in_cmd_i);
      kind_q <= in_data_i[7:0];
      len_q  <= in_data_i[15:8];
      data_q <= in_data_i[79:16];
      ack_q  <= in_data_i[111:80];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seq_mem[wr_addr]  <= wr_seq;
      kind_mem[wr_addr] <= wr_kind;
      data_mem[wr_addr] <= wr_data;
    end
    rd_seq_q  <= seq_mem[head_q];
    rd_kind_q <= kind_mem[head_q];
    rd_data_q <= data_mem[head_q];
  end

  always_comb begin
    head_valid = (cnt_q != '0);
    show_seq   = head_valid ? rd_seq_q  : '0;
    show_kind  = head_valid ? rd_kind_q : '0;
    show_data  = head_valid ? rd_data_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_data_q <= {(OUT_TDATA_W - 113)'(0), 5'(cnt_q), show_data, show_kind, show_seq,
                     head_valid, queued_q, status_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign stat_o.is_session = (cmd_q == CMD_SESSION);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("frame count beyond ring depth");

  a_session_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.sess2 |=> (cnt_q == CNT_W'(2)) && (head_q == '0) && online_q)
    else $error("session did not queue both reports");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && wr_en && (cmd_q == CMD_PUSH)) |-> can_enq && online_q)
    else $error("ring written while full or offline");

endmodule

// File: sv/acked_report_queue.sv
// Top level of the acked report queue: controller plus datapath.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: command; tdata: kind,len,data,ack
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: status..queue_count
//  cfg       in   cfg_we_i                         cfg_idx_i, cfg_wdata_i
//
// Each word passes through latch, execute, second ring write (session only),
// head read and result load, which waits until the output register frees.
// The ring has a single write port, so a session writes its two frames in turn.
// Reset is asynchronous, active low; the ring contents are not cleared.
// A result waiting on m_axis does not block the next accept; a second result
// holds in the controller until the output register frees.
module acked_report_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] report_kind, [15:8] report_length, [79:16] report_data,
  // [111:80] ack_sequence
  input  logic [arq_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [2] report_queued, [3] head_valid, [35:4] head_sequence,
  // [43:36] head_kind, [107:44] head_data, [112:108] queue_count, rest zero
  output logic [arq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [arq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [arq_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import arq_pkg::*;

  arq_ctl_t  ctl;
  arq_stat_t stat;

  arq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  arq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .ctl_i       (ctl),
    .stat_o      (stat)
  );

endmodule
